/* design/irfd_pkg.sv */
// irfd_pkg: shared types, register indexes, reset values and code tables
// for the ir remote frame decoder; no dependencies
`default_nettype none

package irfd_pkg;

	// default structural parameters
	localparam int FRAME_BITS_DEF  = 12;
	localparam int PREFIX_BITS_DEF = 5;
	localparam int KEY_COUNT_DEF   = 5;

	localparam int PREFIX_ENTRIES = 5;
	localparam int KEY_ENTRIES    = 5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_TICKS     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BACKLIGHT_GATE = 3'd7;

	// item operation codes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic [15:0] glitch_limit;
		logic [15:0] one_min;
		logic [15:0] one_max;
		logic [15:0] zero_min;
		logic [15:0] zero_max;
		logic [3:0]  lock_ticks;
		logic [2:0]  idle_ticks;
		logic        backlight_gate;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		glitch_limit:   16'd20,
		one_min:        16'd90,
		one_max:        16'd150,
		zero_min:       16'd25,
		zero_max:       16'd60,
		lock_ticks:     4'd9,
		idle_ticks:     3'd4,
		backlight_gate: 1'b1
	};

	typedef struct packed {
		logic        operation;
		logic [15:0] interval;
		logic        line_idle;
		logic        standby;
	} item_t;

	typedef struct packed {
		logic [2:0] key_value;
		logic       key_locked;
		logic       key_accepted;
		logic       backlight_request;
		logic       frame_error;
	} result_t;

	// expected code after n bits, n = 1..4
	function automatic logic [7:0] prefix_code(input logic [3:0] n);
		logic [7:0] c;
		unique case (n)
			4'd1: c = 8'h01;
			4'd2: c = 8'h03;
			4'd3: c = 8'h06;
			4'd4: c = 8'h0D;
			default: c = 8'h01;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] key_code(input logic [2:0] k);
		logic [7:0] c;
		unique case (k)
			3'd0: c = 8'h81;
			3'd1: c = 8'h90;
			3'd2: c = 8'h88;
			3'd3: c = 8'h84;
			default: c = 8'hC3;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] key_val(input logic [2:0] k);
		logic [2:0] v;
		unique case (k)
			3'd0: v = 3'd1;
			3'd1: v = 3'd2;
			3'd2: v = 3'd3;
			3'd3: v = 3'd4;
			default: v = 3'd6;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* design/irfd_if.sv */
// irfd channel interfaces: input items, result items and register writes
// depends on irfd_pkg
`default_nettype none

interface irfd_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] interval;
	logic        line_idle;
	logic        standby;

	modport source (output valid, operation, interval, line_idle, standby, input ready);
	modport sink (input valid, operation, interval, line_idle, standby, output ready);
endinterface

interface irfd_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] key_value;
	logic       key_locked;
	logic       key_accepted;
	logic       backlight_request;
	logic       frame_error;

	modport source (output valid, key_value, key_locked, key_accepted, backlight_request,
		frame_error, input ready);
	modport sink (input valid, key_value, key_locked, key_accepted, backlight_request,
		frame_error, output ready);
endinterface

interface irfd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [irfd_pkg::CFG_IDX_W-1:0]  index;
	logic [irfd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/ir_remote_frame_decoder.sv */
// ir_remote_frame_decoder: top level, input register, decoder core and result register
// depends on irfd_pkg, irfd_if, irfd_cfg_regs and irfd_core
//
//   port     dir   contents
//   item     sink  operation, interval, line_idle, standby
//   result   src   key_value, key_locked, key_accepted, backlight_request, frame_error
//   cfg      sink  index, data (register write, always ready)
//
// one item per cycle sustained while the result is not stalled; an item taken into the
// input register is decoded in the next cycle and loaded into the result register when
// the result slot is free or being emptied. the decode logic updates the state as the
// item moves on.
// arst_n clears the state and the valid flags and resets the config registers.
// a stalled result holds; the input register still takes one more item behind it.
`default_nettype none

module ir_remote_frame_decoder #(
	parameter int FRAME_BITS  = irfd_pkg::FRAME_BITS_DEF,
	parameter int PREFIX_BITS = irfd_pkg::PREFIX_BITS_DEF,
	parameter int KEY_COUNT   = irfd_pkg::KEY_COUNT_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	irfd_item_if.sink    item,
	irfd_result_if.source result,
	irfd_cfg_if.sink     cfg
);

	irfd_pkg::cfg_t    regs;
	irfd_pkg::item_t   item_s1;
	logic              valid_s1;
	irfd_pkg::result_t res_d;
	irfd_pkg::result_t result_q;
	logic              out_valid_q;
	logic              take;

	irfd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// the staged item moves on when the result slot is free or being emptied
	assign take       = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.operation <= item.operation;
			item_s1.interval  <= item.interval;
			item_s1.line_idle <= item.line_idle;
			item_s1.standby   <= item.standby;
		end
	end

	irfd_core #(
		.FRAME_BITS  (FRAME_BITS),
		.PREFIX_BITS (PREFIX_BITS),
		.KEY_COUNT   (KEY_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (take),
		.item   (item_s1),
		.regs   (regs),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res_d;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.key_value         = result_q.key_value;
	assign result.key_locked        = result_q.key_locked;
	assign result.key_accepted      = result_q.key_accepted;
	assign result.backlight_request = result_q.backlight_request;
	assign result.frame_error       = result_q.frame_error;

endmodule

`default_nettype wire

/* design/irfd_cfg_regs.sv */
// irfd_cfg_regs: configuration register file written through the cfg channel
// depends on irfd_pkg and irfd_cfg_if
`default_nettype none

module irfd_cfg_regs (
	input  wire logic       clk,
	input  wire logic       arst_n,
	irfd_cfg_if.sink        cfg,
	output irfd_pkg::cfg_t  regs
);

	irfd_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= irfd_pkg::CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				irfd_pkg::REG_GLITCH_LIMIT:   regs_q.glitch_limit   <= cfg.data;
				irfd_pkg::REG_ONE_MIN:        regs_q.one_min        <= cfg.data;
				irfd_pkg::REG_ONE_MAX:        regs_q.one_max        <= cfg.data;
				irfd_pkg::REG_ZERO_MIN:       regs_q.zero_min       <= cfg.data;
				irfd_pkg::REG_ZERO_MAX:       regs_q.zero_max       <= cfg.data;
				irfd_pkg::REG_LOCK_TICKS:     regs_q.lock_ticks     <= cfg.data[3:0];
				irfd_pkg::REG_IDLE_TICKS:     regs_q.idle_ticks     <= cfg.data[2:0];
				irfd_pkg::REG_BACKLIGHT_GATE: regs_q.backlight_gate <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/irfd_core.sv */
// irfd_core: decoder state and the next-state / result logic for one item
// depends on irfd_pkg
`default_nettype none

module irfd_core #(
	parameter int FRAME_BITS  = irfd_pkg::FRAME_BITS_DEF,
	parameter int PREFIX_BITS = irfd_pkg::PREFIX_BITS_DEF,
	parameter int KEY_COUNT   = irfd_pkg::KEY_COUNT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire irfd_pkg::item_t item,
	input  wire irfd_pkg::cfg_t  regs,
	output irfd_pkg::result_t  res
);

	localparam logic [3:0] FRAME_CNT  = 4'(FRAME_BITS);
	localparam logic [3:0] PREFIX_CNT = 4'(PREFIX_BITS);
	localparam logic [3:0] PREFIX_TAB = 4'(irfd_pkg::PREFIX_ENTRIES);

	logic       lead_q;
	logic [3:0] bit_cnt_q;
	logic [7:0] code_q;
	logic       lock_q;
	logic [2:0] key_q;
	logic [3:0] lock_tmr_q;
	logic [2:0] idle_cnt_q;

	logic       lead_d;
	logic [3:0] bit_cnt_d;
	logic [7:0] code_d;
	logic       lock_d;
	logic [2:0] key_d;
	logic [3:0] lock_tmr_d;
	logic [2:0] idle_cnt_d;

	logic       accepted;
	logic       backlight;
	logic       err;

	logic [3:0] bc1;
	logic [7:0] sc1;
	logic       is_one;
	logic       is_zero;
	logic       hit;
	logic [2:0] hit_val;
	logic       end_frame;
	logic [4:0] lock_inc;
	logic [3:0] idle_inc;

	always_comb begin
		is_one  = (item.interval > regs.one_min) && (item.interval < regs.one_max);
		is_zero = (item.interval > regs.zero_min) && (item.interval < regs.zero_max);
		bc1     = bit_cnt_q + 4'd1;
		sc1     = {code_q[6:0], is_one};

		// first matching key among the enabled entries
		hit     = 1'b0;
		hit_val = '0;
		for (int i = 0; i < irfd_pkg::KEY_ENTRIES; i++) begin
			if (!hit && i < KEY_COUNT && sc1 == irfd_pkg::key_code(3'(i))) begin
				hit     = 1'b1;
				hit_val = irfd_pkg::key_val(3'(i));
			end
		end

		lock_inc = {1'b0, lock_tmr_q} + 5'd1;
		idle_inc = {1'b0, idle_cnt_q} + 4'd1;

		lead_d     = lead_q;
		bit_cnt_d  = bit_cnt_q;
		code_d     = code_q;
		lock_d     = lock_q;
		key_d      = key_q;
		lock_tmr_d = lock_tmr_q;
		idle_cnt_d = idle_cnt_q;
		accepted   = 1'b0;
		backlight  = 1'b0;
		err        = 1'b0;
		end_frame  = 1'b0;

		if (item.operation == irfd_pkg::OP_TICK) begin
			if (lock_q) begin
				if (lock_inc > {1'b0, regs.lock_ticks}) begin
					lock_tmr_d = '0;
					key_d      = '0;
					lock_d     = 1'b0;
				end else begin
					lock_tmr_d = lock_inc[3:0];
				end
			end
			if (item.line_idle) begin
				if (idle_inc > {1'b0, regs.idle_ticks}) begin
					idle_cnt_d = '0;
					lead_d     = 1'b0;
				end else begin
					idle_cnt_d = idle_inc[2:0];
				end
			end else begin
				idle_cnt_d = '0;
			end
		end else if (item.interval >= regs.glitch_limit) begin
			if (!lead_q) begin
				lead_d    = 1'b1;
				bit_cnt_d = '0;
				code_d    = '0;
			end else if (!is_one && !is_zero) begin
				err       = 1'b1;
				end_frame = 1'b1;
			end else if (bc1 == FRAME_CNT) begin
				end_frame = 1'b1;
				if (hit && !lock_q) begin
					key_d     = hit_val;
					lock_d    = 1'b1;
					accepted  = 1'b1;
					backlight = !regs.backlight_gate || hit_val == 3'd1 || item.standby;
				end
			end else if (bc1 < PREFIX_CNT && bc1 < PREFIX_TAB
				&& sc1 != irfd_pkg::prefix_code(bc1)) begin
				err       = 1'b1;
				end_frame = 1'b1;
			end else begin
				bit_cnt_d = bc1;
				code_d    = sc1;
			end
		end

		if (end_frame) begin
			bit_cnt_d = '0;
			code_d    = '0;
			lead_d    = 1'b0;
			if (lock_d) begin
				lock_tmr_d = '0;
			end
		end

		res.key_value         = key_d;
		res.key_locked        = lock_d;
		res.key_accepted      = accepted;
		res.backlight_request = backlight;
		res.frame_error       = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q     <= 1'b0;
			bit_cnt_q  <= '0;
			code_q     <= '0;
			lock_q     <= 1'b0;
			key_q      <= '0;
			lock_tmr_q <= '0;
			idle_cnt_q <= '0;
		end else if (fire) begin
			lead_q     <= lead_d;
			bit_cnt_q  <= bit_cnt_d;
			code_q     <= code_d;
			lock_q     <= lock_d;
			key_q      <= key_d;
			lock_tmr_q <= lock_tmr_d;
			idle_cnt_q <= idle_cnt_d;
		end
	end

`ifndef SYNTHESIS
	// a held key is never zero, and no key is kept without the lock
	a_lock_key: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q == (key_q != 3'd0))
		else $error("lock and held key disagree");

	// the frame is cut off before the count reaches the frame length
	a_bit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q < FRAME_CNT)
		else $error("bit count reached frame length");

	a_acc_err: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.key_accepted && res.frame_error))
		else $error("key accepted on a frame error");

	a_backlight: assert property (@(posedge clk) disable iff (!arst_n)
		res.backlight_request |-> res.key_accepted)
		else $error("backlight request without a new key");

	// a new key only comes from an unlocked state and leaves the lock set
	a_accept_lock: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.key_accepted |-> !lock_q ##1 lock_q)
		else $error("key accepted while locked");
`endif

endmodule

`default_nettype wire
